[sv/lmsd_pkg.sv]
// Shared type, constants and helper function of the LED matrix scan driver.
package lmsd_pkg;

    localparam int ROW_PIXELS = 8;
    localparam int ROW_W_BITS = 2 * ROW_PIXELS;
    localparam int GREEN_OFFSET = ROW_PIXELS;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [3:0] NIBBLE_FLIP [16] = '{
        4'h0, 4'h8, 4'h4, 4'hC, 4'h2, 4'hA, 4'h6, 4'hE,
        4'h1, 4'h9, 4'h5, 4'hD, 4'h3, 4'hB, 4'h7, 4'hF
    };

    // Control flags that travel with a tick from the read stage to the output stage.
    typedef struct packed {
        logic valid;
        logic plane_red;
        logic update;
        logic release_pulse;
    } t_stage_ctl;

    function automatic logic [7:0] flip_byte(input logic [7:0] value);
        logic [7:0] flipped;
        flipped = {NIBBLE_FLIP[value[3:0]], NIBBLE_FLIP[value[7:4]]};
        return flipped;
    endfunction

endpackage

[sv/lmsd_frame_buf.sv]
// Frame buffer memory: one red and one green bit per pixel, stored as rows of eight pixels.
module lmsd_frame_buf
    import lmsd_pkg::*;
#(
    parameter int PIXEL_COUNT = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(PIXEL_COUNT)-1:0] i_wr_index,
    input  logic                           i_red_set,
    input  logic                           i_green_set,
    input  logic                           i_rd_en,
    input  logic [$clog2(PIXEL_COUNT)-4:0] i_row_lo,
    input  logic [$clog2(PIXEL_COUNT)-4:0] i_row_hi,
    output logic [ROW_W_BITS-1:0]          o_rd_lo,
    output logic [ROW_W_BITS-1:0]          o_rd_hi,
    output logic                           o_vld_lo,
    output logic                           o_vld_hi
);

    localparam int IDX_W = $clog2(PIXEL_COUNT);
    localparam int ROWS  = PIXEL_COUNT / ROW_PIXELS;
    localparam int ROW_W = IDX_W - 3;

    logic [ROW_W_BITS-1:0] r_mem [ROWS];
    logic [ROWS-1:0]       r_row_vld;
    logic [ROW_W_BITS-1:0] r_rd_lo;
    logic [ROW_W_BITS-1:0] r_rd_hi;
    logic                  r_vld_lo;
    logic                  r_vld_hi;

    logic                  wr_in_range;
    logic [ROW_W-1:0]      wr_row;
    logic [2:0]            wr_pos;
    logic [ROW_W_BITS-1:0] fresh_row;

    assign wr_in_range = ({1'b0, i_wr_index} < (IDX_W + 1)'(PIXEL_COUNT));
    assign wr_row      = i_wr_index[IDX_W-1:3];
    assign wr_pos      = i_wr_index[2:0];

    always_comb begin
        fresh_row = '0;
        fresh_row[wr_pos] = i_red_set;
        fresh_row[GREEN_OFFSET + 32'(wr_pos)] = i_green_set;
    end

    // A row that was never written holds stale contents, so its first write stores
    // the whole row with the other pixels dark.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            if (r_row_vld[wr_row]) begin
                r_mem[wr_row][wr_pos] <= i_red_set;
                r_mem[wr_row][GREEN_OFFSET + 32'(wr_pos)] <= i_green_set;
            end else begin
                r_mem[wr_row] <= fresh_row;
            end
        end
        if (i_rd_en) begin
            r_rd_lo <= r_mem[i_row_lo];
            r_rd_hi <= r_mem[i_row_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_vld_lo  <= 1'b0;
            r_vld_hi  <= 1'b0;
        end else begin
            if (i_wr_en && wr_in_range) begin
                r_row_vld[wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_lo <= r_row_vld[i_row_lo];
                r_vld_hi <= r_row_vld[i_row_hi];
            end
        end
    end

    assign o_rd_lo  = r_rd_lo;
    assign o_rd_hi  = r_rd_hi;
    assign o_vld_lo = r_vld_lo;
    assign o_vld_hi = r_vld_hi;

endmodule

[sv/lmsd_scan_ctrl.sv]
// Scan sequencer: phase, row pointers, last driven column, frame counter and read stage flags.
module lmsd_scan_ctrl
    import lmsd_pkg::*;
#(
    parameter int PIXEL_COUNT        = 128,
    parameter int SCAN_PHASES        = 16,
    parameter int FRAMES_PER_RELEASE = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick,
    input  logic                           i_advance,
    output logic [$clog2(PIXEL_COUNT)-4:0] o_row_lo,
    output logic [$clog2(PIXEL_COUNT)-4:0] o_row_hi,
    output t_stage_ctl                     o_ctl,
    output logic [$clog2(SCAN_PHASES)-1:0] o_phase
);

    localparam int ROWS    = PIXEL_COUNT / ROW_PIXELS;
    localparam int ROW_W   = $clog2(PIXEL_COUNT) - 3;
    localparam int PHASE_W = $clog2(SCAN_PHASES);
    localparam int FRAME_W = (FRAMES_PER_RELEASE > 1) ? $clog2(FRAMES_PER_RELEASE) : 1;

    logic [PHASE_W-1:0] r_phase,    n_phase;
    logic [PHASE_W-1:0] r_last_col, n_last_col;
    logic [ROW_W-1:0]   r_row_lo,   n_row_lo;
    logic [ROW_W-1:0]   r_row_hi,   n_row_hi;
    logic [FRAME_W-1:0] r_frame,    n_frame;
    t_stage_ctl         r_ctl,      n_ctl;
    logic [PHASE_W-1:0] r_s1_phase, n_s1_phase;

    logic wrap;

    always_comb begin
        n_phase    = r_phase;
        n_last_col = r_last_col;
        n_row_lo   = r_row_lo;
        n_row_hi   = r_row_hi;
        n_frame    = r_frame;
        n_ctl      = r_ctl;
        n_s1_phase = r_s1_phase;
        wrap       = (r_phase == PHASE_W'(SCAN_PHASES - 1));

        if (i_advance) begin
            n_ctl.valid = 1'b0;
        end

        if (i_tick) begin
            n_ctl.valid         = 1'b1;
            n_ctl.plane_red     = r_phase[0];
            n_ctl.update        = (r_phase != r_last_col);
            n_ctl.release_pulse = 1'b0;
            n_s1_phase          = r_phase;
            n_last_col          = r_phase;

            if (wrap) begin
                n_phase  = '0;
                n_row_lo = '0;
                n_row_hi = ROW_W'(ROWS / 2);
                n_frame  = (r_frame == FRAME_W'(FRAMES_PER_RELEASE - 1)) ? '0 : r_frame + 1'b1;
                n_ctl.release_pulse = (n_frame == '0);
            end else begin
                n_phase = r_phase + 1'b1;
                // Each pair of phases shares one row of eight pixels.
                if (r_phase[0]) begin
                    n_row_lo = (r_row_lo == ROW_W'(ROWS - 1)) ? '0 : r_row_lo + 1'b1;
                    n_row_hi = (r_row_hi == ROW_W'(ROWS - 1)) ? '0 : r_row_hi + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_last_col <= '0;
            r_row_lo   <= '0;
            r_row_hi   <= ROW_W'(ROWS / 2);
            r_frame    <= '0;
            r_ctl      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_last_col <= n_last_col;
            r_row_lo   <= n_row_lo;
            r_row_hi   <= n_row_hi;
            r_frame    <= n_frame;
            r_ctl      <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_phase <= n_s1_phase;
    end

    assign o_row_lo = r_row_lo;
    assign o_row_hi = r_row_hi;
    assign o_ctl    = r_ctl;
    assign o_phase  = r_s1_phase;

    a_row_hi_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row_hi) == (32'(r_row_lo) + ROWS / 2) % ROWS)
        else $error("high half row pointer lost its offset from the low half");

    a_release_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && r_ctl.release_pulse |-> r_s1_phase == PHASE_W'(SCAN_PHASES - 1))
        else $error("release pulse outside the last phase of a frame");

    a_last_col_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> r_last_col == $past(r_phase))
        else $error("last column does not follow the scanned phase");

endmodule

[sv/lmsd_drive_out.sv]
// Output stage: selects the colour plane, bit-reverses the rows and holds the drives.
module lmsd_drive_out
    import lmsd_pkg::*;
#(
    parameter int SCAN_PHASES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_stall,
    input  t_stage_ctl                     i_ctl,
    input  logic [$clog2(SCAN_PHASES)-1:0] i_phase,
    input  logic [ROW_W_BITS-1:0]          i_rd_lo,
    input  logic [ROW_W_BITS-1:0]          i_rd_hi,
    input  logic                           i_vld_lo,
    input  logic                           i_vld_hi,
    output logic                           o_valid,
    output logic [7:0]                     o_row_drive_b,
    output logic [7:0]                     o_row_drive_a,
    output logic [$clog2(SCAN_PHASES)-1:0] o_column_select,
    output logic                           o_drive_updated,
    output logic                           o_release_wait
);

    localparam int PHASE_W = $clog2(SCAN_PHASES);

    logic               r_valid,   n_valid;
    logic [7:0]         r_held_b,  n_held_b;
    logic [7:0]         r_held_a,  n_held_a;
    logic [PHASE_W-1:0] r_column;
    logic               r_updated;
    logic               r_release;

    logic [ROW_W_BITS-1:0] row_lo;
    logic [ROW_W_BITS-1:0] row_hi;
    logic [7:0]            byte_lo;
    logic [7:0]            byte_hi;

    // A row that was never written reads as dark.
    assign row_lo  = i_vld_lo ? i_rd_lo : '0;
    assign row_hi  = i_vld_hi ? i_rd_hi : '0;
    assign byte_lo = i_ctl.plane_red ? row_lo[ROW_PIXELS-1:0] : row_lo[ROW_W_BITS-1:GREEN_OFFSET];
    assign byte_hi = i_ctl.plane_red ? row_hi[ROW_PIXELS-1:0] : row_hi[ROW_W_BITS-1:GREEN_OFFSET];

    always_comb begin
        n_held_b = r_held_b;
        n_held_a = r_held_a;
        n_valid  = r_valid && i_stall;
        if (i_advance) begin
            n_valid = 1'b1;
            if (i_ctl.update) begin
                n_held_b = flip_byte(byte_lo);
                n_held_a = flip_byte(byte_hi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_held_b <= '0;
            r_held_a <= '0;
        end else begin
            r_valid  <= n_valid;
            r_held_b <= n_held_b;
            r_held_a <= n_held_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_column  <= i_phase;
            r_updated <= i_ctl.update;
            r_release <= i_ctl.release_pulse;
        end
    end

    assign o_valid         = r_valid;
    assign o_row_drive_b   = r_held_b;
    assign o_row_drive_a   = r_held_a;
    assign o_column_select = r_column;
    assign o_drive_updated = r_updated;
    assign o_release_wait  = r_release;

    a_hold_without_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_ctl.update |=> $stable(r_held_b) && $stable(r_held_a))
        else $error("held drives changed on a tick that repeats the column");

endmodule

[sv/led_matrix_scan_driver_top.sv]
// LED matrix scan driver: scan tick and pixel write requests in, column drive results out.
// A tick request's result passes the registered frame buffer read, then the output register.
// One request is accepted every cycle while the result side takes results; writes give none.
// Synchronous active-low reset clears the scan state, the held drives and the row valid
// bits, so the whole frame reads dark at once with no clearing pass.
module led_matrix_scan_driver_top
    import lmsd_pkg::*;
#(
    parameter int PIXEL_COUNT        = 128,
    parameter int SCAN_PHASES        = 16,
    parameter int FRAMES_PER_RELEASE = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic [$clog2(PIXEL_COUNT)-1:0] i_pixel_index,
    input  logic [7:0]                     i_red_level,
    input  logic [7:0]                     i_green_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_row_drive_b,
    output logic [7:0]                     o_row_drive_a,
    output logic [$clog2(SCAN_PHASES)-1:0] o_column_select,
    output logic                           o_drive_updated,
    output logic                           o_release_wait
);

    // PIXEL_COUNT is taken to be a multiple of 16 so both halves start on a row.
    localparam int ROW_W = $clog2(PIXEL_COUNT) - 3;

    logic                           accept;
    logic                           tick_acc;
    logic                           write_acc;
    logic                           advance;
    logic [ROW_W-1:0]               row_lo;
    logic [ROW_W-1:0]               row_hi;
    t_stage_ctl                     s1_ctl;
    logic [$clog2(SCAN_PHASES)-1:0] s1_phase;
    logic [ROW_W_BITS-1:0]          rd_lo;
    logic [ROW_W_BITS-1:0]          rd_hi;
    logic                           vld_lo;
    logic                           vld_hi;

    assign advance   = s1_ctl.valid && !(o_valid && i_stall);
    assign o_stall   = s1_ctl.valid && o_valid && i_stall;
    assign accept    = i_valid && !o_stall;
    assign tick_acc  = accept && (i_func == FUNC_TICK);
    assign write_acc = accept && (i_func == FUNC_WRITE);

    lmsd_scan_ctrl #(
        .PIXEL_COUNT        (PIXEL_COUNT),
        .SCAN_PHASES        (SCAN_PHASES),
        .FRAMES_PER_RELEASE (FRAMES_PER_RELEASE)
    ) u_scan_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick_acc),
        .i_advance (advance),
        .o_row_lo  (row_lo),
        .o_row_hi  (row_hi),
        .o_ctl     (s1_ctl),
        .o_phase   (s1_phase)
    );

    lmsd_frame_buf #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_frame_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (write_acc),
        .i_wr_index  (i_pixel_index),
        .i_red_set   (i_red_level != 8'd0),
        .i_green_set (i_green_level != 8'd0),
        .i_rd_en     (tick_acc),
        .i_row_lo    (row_lo),
        .i_row_hi    (row_hi),
        .o_rd_lo     (rd_lo),
        .o_rd_hi     (rd_hi),
        .o_vld_lo    (vld_lo),
        .o_vld_hi    (vld_hi)
    );

    lmsd_drive_out #(
        .SCAN_PHASES (SCAN_PHASES)
    ) u_drive_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_stall         (i_stall),
        .i_ctl           (s1_ctl),
        .i_phase         (s1_phase),
        .i_rd_lo         (rd_lo),
        .i_rd_hi         (rd_hi),
        .i_vld_lo        (vld_lo),
        .i_vld_hi        (vld_hi),
        .o_valid         (o_valid),
        .o_row_drive_b   (o_row_drive_b),
        .o_row_drive_a   (o_row_drive_a),
        .o_column_select (o_column_select),
        .o_drive_updated (o_drive_updated),
        .o_release_wait  (o_release_wait)
    );

endmodule
